FILE: design/frs_pkg.sv
// Shared types, register indexes and reset values for the feeder reload sequencer.
// Depends on nothing; every other design file refers to it by scoped name.
`default_nettype none

package frs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FEED_SPEED      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_SPEED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_OFFSET  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_WORK_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_WORK_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALL_LIMIT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_TARGET    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_TARGET     = 3'd7;

    // Configuration reset values
    localparam logic signed [14:0] FEED_SPEED_RST      = 15'sd2000;
    localparam logic signed [14:0] REVERSE_SPEED_RST   = -15'sd2000;
    localparam logic signed [20:0] REVERSE_OFFSET_RST  = -21'sd8192;
    localparam logic [15:0]        INIT_WORK_LIMIT_RST = 16'd2000;
    localparam logic [15:0]        RUN_WORK_LIMIT_RST  = 16'd500;
    localparam logic [7:0]         STALL_LIMIT_RST     = 8'd2;
    localparam logic [13:0]        FRONT_TARGET_RST    = 14'd5150;
    localparam logic [13:0]        BACK_TARGET_RST     = 14'd5150;

    // Flywheel check thresholds
    localparam logic [14:0] LOW_SPEED = 15'd1000;
    localparam logic [15:0] SPEED_TOL = 16'd100;

    typedef enum logic [1:0] {
        PH_SLEEP = 2'd0,
        PH_FWD   = 2'd1,
        PH_REV   = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [31:0] dial_position;
        logic               dial_stalled;
        logic               dial_initialised;
        logic               shot_fired;
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] back_left_speed;
        logic signed [15:0] back_right_speed;
    } frs_in_t;

    typedef struct packed {
        logic signed [14:0] dial_target_speed;
        logic               loaded;
        logic               reload_done;
        logic               flywheels_ready;
        logic [1:0]         phase;
    } frs_out_t;

    typedef struct packed {
        logic signed [14:0] feed_speed;
        logic signed [14:0] reverse_speed;
        logic signed [20:0] reverse_offset;
        logic [15:0]        init_work_limit;
        logic [15:0]        run_work_limit;
        logic [7:0]         stall_limit;
        logic [13:0]        front_target_speed;
        logic [13:0]        back_target_speed;
    } frs_cfg_t;

endpackage

`default_nettype wire

FILE: design/frs_cfg_regs.sv
// Configuration register file for the feeder reload sequencer.
// Depends on frs_pkg for the register indexes, reset values and frs_cfg_t.
`default_nettype none

module frs_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr,
    input  wire logic [frs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [frs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output frs_pkg::frs_cfg_t                     cfg
);

    frs_pkg::frs_cfg_t cfg_reg;
    frs_pkg::frs_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                frs_pkg::CFG_FEED_SPEED:      cfg_next.feed_speed         = cfg_data[14:0];
                frs_pkg::CFG_REVERSE_SPEED:   cfg_next.reverse_speed      = cfg_data[14:0];
                frs_pkg::CFG_REVERSE_OFFSET:  cfg_next.reverse_offset     = cfg_data[20:0];
                frs_pkg::CFG_INIT_WORK_LIMIT: cfg_next.init_work_limit    = cfg_data[15:0];
                frs_pkg::CFG_RUN_WORK_LIMIT:  cfg_next.run_work_limit     = cfg_data[15:0];
                frs_pkg::CFG_STALL_LIMIT:     cfg_next.stall_limit        = cfg_data[7:0];
                frs_pkg::CFG_FRONT_TARGET:    cfg_next.front_target_speed = cfg_data[13:0];
                frs_pkg::CFG_BACK_TARGET:     cfg_next.back_target_speed  = cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.feed_speed         <= frs_pkg::FEED_SPEED_RST;
            cfg_reg.reverse_speed      <= frs_pkg::REVERSE_SPEED_RST;
            cfg_reg.reverse_offset     <= frs_pkg::REVERSE_OFFSET_RST;
            cfg_reg.init_work_limit    <= frs_pkg::INIT_WORK_LIMIT_RST;
            cfg_reg.run_work_limit     <= frs_pkg::RUN_WORK_LIMIT_RST;
            cfg_reg.stall_limit        <= frs_pkg::STALL_LIMIT_RST;
            cfg_reg.front_target_speed <= frs_pkg::FRONT_TARGET_RST;
            cfg_reg.back_target_speed  <= frs_pkg::BACK_TARGET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/frs_flywheel_check.sv
// Flywheel ready check: saturating absolute speeds, low-speed and tolerance compares.
// Depends on frs_pkg for frs_in_t, frs_cfg_t and the speed thresholds.
`default_nettype none

module frs_flywheel_check (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire frs_pkg::frs_in_t  item,
    input  wire frs_pkg::frs_cfg_t cfg,
    output logic                   ready_next
);

    logic        ready_reg;
    logic [14:0] abs_fl, abs_fr, abs_bl, abs_br;
    logic        any_low, all_near;

    // |v| clipped to 15 bits; only the most negative code needs the clip
    function automatic logic [14:0] abs_sat(input logic signed [15:0] v);
        logic [15:0] mag;
        mag = v[15] ? (~v + 16'd1) : v;
        return mag[15] ? 15'h7FFF : mag[14:0];
    endfunction

    function automatic logic near(input logic [14:0] a, input logic [13:0] t);
        logic [15:0] a_w, t_w;
        a_w = {1'b0, a};
        t_w = {2'b00, t};
        return (a_w <= t_w + frs_pkg::SPEED_TOL) && (t_w <= a_w + frs_pkg::SPEED_TOL);
    endfunction

    always_comb begin
        abs_fl   = abs_sat(item.front_left_speed);
        abs_fr   = abs_sat(item.front_right_speed);
        abs_bl   = abs_sat(item.back_left_speed);
        abs_br   = abs_sat(item.back_right_speed);
        any_low  = (abs_fl < frs_pkg::LOW_SPEED) || (abs_fr < frs_pkg::LOW_SPEED) ||
                   (abs_bl < frs_pkg::LOW_SPEED) || (abs_br < frs_pkg::LOW_SPEED);
        all_near = near(abs_fl, cfg.front_target_speed) &&
                   near(abs_fr, cfg.front_target_speed) &&
                   near(abs_bl, cfg.back_target_speed) &&
                   near(abs_br, cfg.back_target_speed);
        // clear on low speed, set when on target, hold otherwise
        if (any_low) begin
            ready_next = 1'b0;
        end else if (all_near) begin
            ready_next = 1'b1;
        end else begin
            ready_next = ready_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else if (step_en) begin
            ready_reg <= ready_next;
        end
    end

`ifndef SYNTHESIS
    a_low_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && any_low |=> !ready_reg)
        else $error("flywheel ready survived a low speed");
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(ready_reg))
        else $error("flywheel ready changed without a step");
    a_set_on_target: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !any_low && all_near |=> ready_reg)
        else $error("flywheel ready not set with all speeds on target");
`endif

endmodule

`default_nettype wire

FILE: design/frs_feeder_fsm.sv
// Feeder machine (sleep, feed forward, reverse) with its counters and reverse target.
// Depends on frs_pkg for phase_t, frs_in_t, frs_out_t and frs_cfg_t.
`default_nettype none

module frs_feeder_fsm (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire frs_pkg::frs_in_t  item,
    input  wire frs_pkg::frs_cfg_t cfg,
    input  wire logic              ready_now,
    output frs_pkg::frs_out_t      result
);

    frs_pkg::phase_t    phase_reg, phase_next;
    logic [15:0]        work_count_reg, work_count_next;
    logic [7:0]         stall_count_reg, stall_count_next;
    logic signed [31:0] reverse_target_reg, reverse_target_next;
    logic signed [14:0] speed_reg, speed_next;
    logic               loaded_reg, loaded_next;

    logic               finish;
    logic               loaded_mid;
    logic [15:0]        limit;
    logic [7:0]         stall_inc;
    logic [32:0]        rev_sum;
    logic signed [31:0] rev_sat;

    always_comb begin
        rev_sum = {item.dial_position[31], item.dial_position} +
                  {{12{cfg.reverse_offset[20]}}, cfg.reverse_offset};
        if (rev_sum[32] != rev_sum[31]) begin
            rev_sat = rev_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            rev_sat = rev_sum[31:0];
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        work_count_next     = work_count_reg;
        stall_count_next    = stall_count_reg;
        reverse_target_next = reverse_target_reg;
        speed_next          = speed_reg;
        finish              = 1'b0;
        loaded_mid          = loaded_reg & ~item.shot_fired;
        limit               = item.dial_initialised ? cfg.run_work_limit : cfg.init_work_limit;
        stall_inc           = stall_count_reg + 8'd1;

        unique case (phase_reg)
            frs_pkg::PH_SLEEP: begin
                work_count_next  = '0;
                speed_next       = '0;
                stall_count_next = '0;
                if (!loaded_mid && ready_now) begin
                    phase_next = frs_pkg::PH_FWD;
                end
            end
            frs_pkg::PH_FWD: begin
                if (!item.dial_stalled) begin
                    if (work_count_reg >= limit) begin
                        finish = 1'b1;
                    end else begin
                        speed_next      = cfg.feed_speed;
                        work_count_next = work_count_reg + 16'd1;
                    end
                end else begin
                    stall_count_next = stall_inc;
                    if (stall_inc < cfg.stall_limit) begin
                        reverse_target_next = rev_sat;
                        work_count_next     = '0;
                        phase_next          = frs_pkg::PH_REV;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            frs_pkg::PH_REV: begin
                if (item.dial_stalled || (item.dial_position <= reverse_target_reg)) begin
                    phase_next = frs_pkg::PH_FWD;
                end else if (work_count_reg >= limit) begin
                    finish = 1'b1;
                end else begin
                    work_count_next = work_count_reg + 16'd1;
                    speed_next      = cfg.reverse_speed;
                end
            end
            default: ;
        endcase

        loaded_next = loaded_mid;
        if (finish) begin
            work_count_next  = '0;
            speed_next       = '0;
            stall_count_next = '0;
            loaded_next      = 1'b1;
            phase_next       = frs_pkg::PH_SLEEP;
        end

        result.dial_target_speed = speed_next;
        result.loaded            = loaded_next;
        result.reload_done       = finish;
        result.flywheels_ready   = ready_now;
        result.phase             = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= frs_pkg::PH_SLEEP;
            work_count_reg     <= '0;
            stall_count_reg    <= '0;
            reverse_target_reg <= '0;
            speed_reg          <= '0;
            loaded_reg         <= 1'b0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            work_count_reg     <= work_count_next;
            stall_count_reg    <= stall_count_next;
            reverse_target_reg <= reverse_target_next;
            speed_reg          <= speed_next;
            loaded_reg         <= loaded_next;
        end
    end

`ifndef SYNTHESIS
    a_reset_sleep: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == frs_pkg::PH_SLEEP)
        else $error("feeder not asleep after reset");
    a_sleep_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == frs_pkg::PH_SLEEP |-> work_count_reg == '0 && stall_count_reg == '0)
        else $error("counters left nonzero in sleep");
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && finish |=> loaded_reg && phase_reg == frs_pkg::PH_SLEEP && speed_reg == '0)
        else $error("reload completion did not load and park the feeder");
`endif

endmodule

`default_nettype wire

FILE: design/feeder_reload_sequencer.sv
// Top level of the feeder reload sequencer: input register, step logic, result register.
// Depends on frs_pkg, frs_cfg_regs, frs_flywheel_check and frs_feeder_fsm.
//
// Usage:
//   s_valid/s_ready/s_data carry one control tick per request (position, stall,
//   initialised and shot flags, four flywheel speeds). m_valid/m_ready/m_data
//   return exactly one result per request: feeder target speed, loaded flag,
//   reload-done pulse, flywheel ready flag and feeder phase.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write one of eight registers;
//   cfg_ready is always high. Write only while no request is in flight.
// Path: an accepted request waits in the input register, is stepped and is written
//   to the result register that drives m_data. Throughput: one request per cycle
//   while m_ready is high. The step is a single pass of compares, a 33-bit
//   saturating add and 16- and 8-bit counters between the two registers.
// Stall: when m_ready is low the result register holds, the input register
//   keeps the next request and s_ready drops once both are full; nothing is
//   lost or replayed, and the feeder state advances only when a request
//   moves into the result register.
// Reset: aresetn is synchronous and active low; both registers empty, feeder
//   asleep, not loaded, flywheels not ready, configuration at defaults.
`default_nettype none

module feeder_reload_sequencer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire frs_pkg::frs_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output frs_pkg::frs_out_t                     m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [frs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [frs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              in_valid_reg, in_valid_next;
    frs_pkg::frs_in_t  in_data_reg;
    logic              out_valid_reg, out_valid_next;
    frs_pkg::frs_out_t out_data_reg;
    logic              advance;
    logic              ready_now;
    frs_pkg::frs_cfg_t cfg;
    frs_pkg::frs_out_t step_result;

    // Step the held request whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    frs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frs_flywheel_check u_fly (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_data_reg),
        .cfg        (cfg),
        .ready_next (ready_now)
    );

    frs_feeder_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (in_data_reg),
        .cfg       (cfg),
        .ready_now (ready_now),
        .result    (step_result)
    );

    always_comb begin
        // Hold the input slot until it is stepped, refill on accept
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
        // Drop the result once taken, load a new one on each step
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request not held in the input register");
    a_done_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reload_done |->
            m_data.loaded && m_data.phase == frs_pkg::PH_SLEEP)
        else $error("reload done reported outside a loaded sleep");
    a_sleep_no_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.phase == frs_pkg::PH_SLEEP |-> m_data.dial_target_speed == '0)
        else $error("feeder commanded to move while asleep");
    a_step_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("stepped request did not reach the result register");
`endif

endmodule

`default_nettype wire

FILE: sim/feeder_reload_sequencer_tb.sv
// Self-checking bench for feeder_reload_sequencer: directed ticks, then random phases.
// Carries its own tick-by-tick model of the feeder machine and flywheel check.
// Depends on frs_pkg and the feeder_reload_sequencer RTL.
`timescale 1ns / 100ps

module feeder_reload_sequencer_tb;

    import frs_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int TICKS_PER_PHASE = 192;
    localparam int RANDOM_PHASES   = 8;
    localparam int SETTLE_CYCLES   = 4;      // settling margin after the last result
    localparam int CHOKE_CYCLES    = 200;
    localparam int CHOKE_SPACING   = 600;
    localparam int MAX_PRINTED     = 40;

    // Flywheel check thresholds, kept apart from the design's copies
    localparam int SPIN_FLOOR  = 1000;
    localparam int SPIN_WINDOW = 100;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    frs_in_t    s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    frs_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    feeder_reload_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Model state: register copy (written only by the stimulus process,
    // only while the block is idle) and feeder state (advanced by the
    // driver on every accepted request).
    // ------------------------------------------------------------------
    frs_cfg_t cfg_shadow = '{
        feed_speed:         FEED_SPEED_RST,
        reverse_speed:      REVERSE_SPEED_RST,
        reverse_offset:     REVERSE_OFFSET_RST,
        init_work_limit:    INIT_WORK_LIMIT_RST,
        run_work_limit:     RUN_WORK_LIMIT_RST,
        stall_limit:        STALL_LIMIT_RST,
        front_target_speed: FRONT_TARGET_RST,
        back_target_speed:  BACK_TARGET_RST
    };

    phase_t             feed_ph;
    logic [15:0]        work_cnt;
    logic [7:0]         stall_cnt;
    int                 rev_target;
    logic signed [14:0] cmd_speed;
    logic               is_loaded;
    logic               fly_ready;

    frs_in_t  tick_backlog[$];     // ticks waiting for the driver
    frs_out_t feeder_outcomes[$];  // predicted results, oldest first

    int ticks_sent  = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    int choke_left  = 0;
    int choke_mark  = 300;
    int burst_left  = 1;
    int gap_left    = 0;
    int gen_pos     = 0;
    int init_bias   = 50;

    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_age   = 0;

    function automatic int sat_abs(input logic signed [15:0] v);
        int a;
        a = v;
        if (a < 0) a = -a;
        return (a > 32767) ? 32767 : a;
    endfunction

    function automatic void end_reload();
        work_cnt  = '0;
        cmd_speed = '0;
        stall_cnt = '0;
        is_loaded = 1'b1;
        feed_ph   = PH_SLEEP;
    endfunction

    // Advance the feeder model by one tick and return what the block must answer.
    function automatic frs_out_t step_feeder(input frs_in_t t);
        int          fl, fr, bl, br, front, back, pos;
        logic [15:0] lim;
        longint      sum;
        frs_out_t    r;
        fl    = sat_abs(t.front_left_speed);
        fr    = sat_abs(t.front_right_speed);
        bl    = sat_abs(t.back_left_speed);
        br    = sat_abs(t.back_right_speed);
        front = int'(cfg_shadow.front_target_speed);
        back  = int'(cfg_shadow.back_target_speed);
        pos   = $signed(t.dial_position);
        lim   = t.dial_initialised ? cfg_shadow.run_work_limit : cfg_shadow.init_work_limit;
        r.reload_done = 1'b0;

        // Flywheel check: any slow wheel clears, all four on target sets, else hold
        if (fl < SPIN_FLOOR || fr < SPIN_FLOOR || bl < SPIN_FLOOR || br < SPIN_FLOOR) begin
            fly_ready = 1'b0;
        end else if (fl - front <= SPIN_WINDOW && front - fl <= SPIN_WINDOW &&
                     fr - front <= SPIN_WINDOW && front - fr <= SPIN_WINDOW &&
                     bl - back  <= SPIN_WINDOW && back  - bl <= SPIN_WINDOW &&
                     br - back  <= SPIN_WINDOW && back  - br <= SPIN_WINDOW) begin
            fly_ready = 1'b1;
        end

        if (t.shot_fired) is_loaded = 1'b0;

        case (feed_ph)
            PH_SLEEP: begin
                work_cnt  = '0;
                cmd_speed = '0;
                stall_cnt = '0;
                if (!is_loaded && fly_ready) feed_ph = PH_FWD;
            end
            PH_FWD: begin
                if (!t.dial_stalled) begin
                    if (work_cnt >= lim) begin
                        end_reload();
                        r.reload_done = 1'b1;
                    end else begin
                        cmd_speed = cfg_shadow.feed_speed;
                        work_cnt  = work_cnt + 16'd1;
                    end
                end else begin
                    stall_cnt = stall_cnt + 8'd1;
                    if (stall_cnt < cfg_shadow.stall_limit) begin
                        // Back off to position plus offset, clamped to 32-bit range
                        sum = longint'(pos) + longint'($signed(cfg_shadow.reverse_offset));
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        rev_target = int'(sum);
                        work_cnt   = '0;
                        feed_ph    = PH_REV;
                    end else begin
                        end_reload();
                        r.reload_done = 1'b1;
                    end
                end
            end
            PH_REV: begin
                if (t.dial_stalled || pos <= rev_target) begin
                    feed_ph = PH_FWD;
                end else if (work_cnt >= lim) begin
                    end_reload();
                    r.reload_done = 1'b1;
                end else begin
                    work_cnt  = work_cnt + 16'd1;
                    cmd_speed = cfg_shadow.reverse_speed;
                end
            end
            default: ;
        endcase

        r.dial_target_speed = cmd_speed;
        r.loaded            = is_loaded;
        r.flywheels_ready   = fly_ready;
        r.phase             = feed_ph;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    // ------------------------------------------------------------------
    // Driver: send queued ticks in bursts with random gaps. Hold valid and
    // payload while the block stalls; predict each request as it is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : tick_driver
        logic    nxt_v;
        frs_in_t nxt_d;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
            feed_ph    = PH_SLEEP;
            work_cnt   = '0;
            stall_cnt  = '0;
            rev_target = 0;
            cmd_speed  = '0;
            is_loaded  = 1'b0;
            fly_ready  = 1'b0;
        end else begin
            nxt_v = s_valid;
            nxt_d = s_data;
            if (s_valid && s_ready) begin
                feeder_outcomes.push_back(step_feeder(s_data));
                ticks_sent <= ticks_sent + 1;
                nxt_v = 1'b0;
            end
            if (!nxt_v) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_backlog.size() != 0) begin
                    nxt_d = tick_backlog.pop_front();
                    nxt_v = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // Long bursts now and then give stretches with no gaps at all
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            s_valid <= nxt_v;
            s_data  <= nxt_d;
        end
    end

    // Hold the receiver off for a long stretch at intervals so the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            choke_left <= 0;
        end else if (choke_left != 0) begin
            choke_left <= choke_left - 1;
        end else if (ticks_sent >= choke_mark) begin
            choke_left <= CHOKE_CYCLES;
            choke_mark <= choke_mark + CHOKE_SPACING;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall on a rotating pattern that is swapped out at random,
    // and compare every accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        frs_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (feeder_outcomes.size() == 0) begin
                    report_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = feeder_outcomes.pop_front();
                    if (m_data.dial_target_speed !== want.dial_target_speed)
                        report_mismatch("dial_target_speed", m_data.dial_target_speed,
                                        want.dial_target_speed);
                    if (m_data.loaded !== want.loaded)
                        report_mismatch("loaded", m_data.loaded, want.loaded);
                    if (m_data.reload_done !== want.reload_done)
                        report_mismatch("reload_done", m_data.reload_done, want.reload_done);
                    if (m_data.flywheels_ready !== want.flywheels_ready)
                        report_mismatch("flywheels_ready", m_data.flywheels_ready,
                                        want.flywheels_ready);
                    if (m_data.phase !== want.phase)
                        report_mismatch("phase", m_data.phase, want.phase);
                end
            end
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'($urandom);
                    2: ready_pat = 16'($urandom | $urandom);
                    default: ready_pat = 16'h0101 << $urandom_range(0, 7);
                endcase
                pat_age = $urandom_range(16, 96);
            end else begin
                pat_age--;
            end
            m_ready   <= (choke_left == 0) && ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    // Give up on a hung block; this also catches predictions never answered.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic frs_in_t tick(input int pos, input bit stalled, input bit initd,
                                     input bit shot, input int fl, input int fr,
                                     input int bl, input int br);
        frs_in_t t;
        t.dial_position     = pos;
        t.dial_stalled      = stalled;
        t.dial_initialised  = initd;
        t.shot_fired        = shot;
        t.front_left_speed  = fl[15:0];
        t.front_right_speed = fr[15:0];
        t.back_left_speed   = bl[15:0];
        t.back_right_speed  = br[15:0];
        return t;
    endfunction

    // Speed close to a target, either direction, sometimes just outside the window.
    function automatic int near_speed(input int tgt);
        int v;
        v = tgt + int'($urandom_range(0, 240)) - 120;
        if (v < 0) v = 0;
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Mostly a plausible tick: dial wanders, flywheels near target, rare stalls
    // and shots. The rest is raw noise across every bit.
    function automatic frs_in_t make_tick();
        frs_in_t      t;
        int           front, back;
        logic [127:0] noise;
        if ($urandom_range(0, 99) < 12) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            t     = noise[$bits(frs_in_t)-1:0];
            return t;
        end
        front   = int'(cfg_shadow.front_target_speed);
        back    = int'(cfg_shadow.back_target_speed);
        gen_pos = gen_pos + int'($urandom_range(0, 6000)) - 3000;
        if ($urandom_range(0, 9) == 0)
            gen_pos = gen_pos + int'($signed(cfg_shadow.reverse_offset)) - 1000;
        t = tick(gen_pos, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < init_bias,
                 $urandom_range(0, 99) < 6, near_speed(front), near_speed(front),
                 near_speed(back), near_speed(back));
        // Drop one wheel below the floor now and then
        if ($urandom_range(0, 49) == 0)
            t.back_right_speed = 16'($urandom_range(0, 999));
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FEED_SPEED:      cfg_shadow.feed_speed         = value[14:0];
            CFG_REVERSE_SPEED:   cfg_shadow.reverse_speed      = value[14:0];
            CFG_REVERSE_OFFSET:  cfg_shadow.reverse_offset     = value[20:0];
            CFG_INIT_WORK_LIMIT: cfg_shadow.init_work_limit    = value[15:0];
            CFG_RUN_WORK_LIMIT:  cfg_shadow.run_work_limit     = value[15:0];
            CFG_STALL_LIMIT:     cfg_shadow.stall_limit        = value[7:0];
            CFG_FRONT_TARGET:    cfg_shadow.front_target_speed = value[13:0];
            CFG_BACK_TARGET:     cfg_shadow.back_target_speed  = value[13:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int feed, input int rev, input int offset,
                                input int init_lim, input int run_lim, input int stall_lim,
                                input int front, input int back);
        write_reg(CFG_FEED_SPEED, feed);
        write_reg(CFG_REVERSE_SPEED, rev);
        write_reg(CFG_REVERSE_OFFSET, offset);
        write_reg(CFG_INIT_WORK_LIMIT, init_lim);
        write_reg(CFG_RUN_WORK_LIMIT, run_lim);
        write_reg(CFG_STALL_LIMIT, stall_lim);
        write_reg(CFG_FRONT_TARGET, front);
        write_reg(CFG_BACK_TARGET, back);
    endtask

    // Wait until every request has been answered, then let the pipeline settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (tick_backlog.size() != 0 || s_valid || feeder_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, default registers: saturating absolute speed, wake, forward,
        // stall with reverse target clamped low, reverse, stall limit reached,
        // sleep while loaded, shot re-arms, slow wheel drops ready.
        @(negedge aclk);
        tick_backlog.push_back(tick(0, 0, 0, 0, -32768, -32768, -32768, -32768));
        tick_backlog.push_back(tick(0, 0, 1, 0, 5150, -5250, 5050, -5200));
        tick_backlog.push_back(tick(100, 0, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(-2147483648 + 100, 1, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 0, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 1, 0, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 1, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 1, 1, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 1, 0, 5150, 999, 5150, 5150));
        tick_backlog.push_back(tick(-1, 0, 0, 0, 32767, -32767, 16384, -1));

        // Zero work limit and zero stall limit: first forward tick or stall ends it
        wait_drained();
        program_regs(2000, -2000, -8192, 0, 0, 0, 5150, 5150);
        @(negedge aclk);
        tick_backlog.push_back(tick(0, 0, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 1, 1, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 0, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 0, 1, 1, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(0, 1, 1, 0, 5150, 5150, 5150, 5150));

        // Positive offset: reverse target clamps at the top of the range
        wait_drained();
        program_regs(2000, -2000, 1048575, 2000, 500, 255, 5150, 5150);
        @(negedge aclk);
        tick_backlog.push_back(tick(0, 0, 1, 1, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(2147483647 - 10, 1, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(2147483647, 0, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(5, 1, 1, 0, 5150, 5150, 5150, 5150));
        tick_backlog.push_back(tick(2000000, 0, 1, 0, 5150, 5150, 5150, 5150));

        // Random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            gen_pos   = $urandom;
            init_bias = $urandom_range(10, 90);
            case (p)
                1: program_regs(16000, -16000, -1048576, 65535, 65535, 255, 16000, 16000);
                2: program_regs(-16000, 16000, 0, 0, 0, 1, 1000, 1000);
                3: program_regs(-16384, 16383, 1048575, 3, 7, 0, 0, 16383);
                4: begin
                    gen_pos = 2147483647 - 200000;
                    program_regs($urandom_range(0, 32000) - 16000,
                                 $urandom_range(0, 32000) - 16000, 1048575,
                                 $urandom_range(0, 40), $urandom_range(0, 40), 255,
                                 $urandom_range(1000, 16000), $urandom_range(1000, 16000));
                end
                7: program_regs(FEED_SPEED_RST, REVERSE_SPEED_RST, REVERSE_OFFSET_RST,
                                INIT_WORK_LIMIT_RST, RUN_WORK_LIMIT_RST, STALL_LIMIT_RST,
                                FRONT_TARGET_RST, BACK_TARGET_RST);
                default: program_regs($urandom_range(0, 32000) - 16000,
                                      $urandom_range(0, 32000) - 16000,
                                      -int'($urandom_range(0, 1048576)),
                                      $urandom_range(0, 60), $urandom_range(0, 60),
                                      $urandom_range(1, 8),
                                      $urandom_range(1000, 16000), $urandom_range(1000, 16000));
            endcase
            @(negedge aclk);
            repeat (TICKS_PER_PHASE) tick_backlog.push_back(make_tick());
        end

        // Anything still predicted but never answered ends in the watchdog
        wait_drained();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
